// ----- rtl/core/ist_pkg.sv -----
`default_nettype none
package ist_pkg;
  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned FieldBits    = 32;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [FieldBits-1:0] range_start;
    logic [FieldBits-1:0] range_end;
  } in_word_t;

  typedef struct packed {
    logic covered;
    logic table_full;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALIGN,
    ST_DONE
  } state_t;
endpackage : ist_pkg
`default_nettype wire

// ----- rtl/core/interval_set_table_top.sv -----
`default_nettype none
// interval_set_table_top: sorted table of disjoint half-open intervals.
// Input channel: drive in_word with start high; the word is taken at the
// first edge where busy is low (mode add, remove or query, range [start,end)).
// Result channel: out_valid pulses for one cycle with covered/table_full.
// The receiver cannot stall; every accepted word yields exactly one result.
// The table is a ring of MAX_RANGES cells that rotates once per word; the
// sequencer sees slot 0 each cycle and shifts the new contents into a second
// ring, merging, trimming or splitting. A split, or an add placed ahead of an
// entry, can yield two entries in one visit; one waits in a pending register
// and holds the scan at its end until it is written. If the new table fits,
// the second ring is turned until its first entry sits in slot 0 and is then
// copied back into the first ring; otherwise the word is dropped with
// table_full and the old table stands.
// A new word is taken only once the last one is through: busy stays high
// from the accepting edge and drops as the strobe rises.
// Reset: entry count cleared, sequencer idle; entries are not cleared, slots
// at or above the count are never consulted.
module interval_set_table_top #(
  parameter int unsigned MAX_RANGES = ist_pkg::MaxRangesDef,
  parameter int unsigned COORD_BITS = ist_pkg::CoordBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ist_pkg::in_word_t in_word,
  output logic                   out_valid,
  output ist_pkg::out_word_t     out_word
);
  import ist_pkg::*;

  localparam int unsigned CntBits = $clog2(MAX_RANGES + 3);
  localparam int unsigned IdxBits = $clog2(MAX_RANGES + 1);
  localparam int unsigned InBits  = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;

  // Two rings: old table (rotates, source) and new table (shifts in).
  logic [COORD_BITS-1:0] old_s [MAX_RANGES];
  logic [COORD_BITS-1:0] old_e [MAX_RANGES];
  logic [COORD_BITS-1:0] new_s [MAX_RANGES];
  logic [COORD_BITS-1:0] new_e [MAX_RANGES];
  logic [COORD_BITS-1:0] old_in_s, old_in_e, new_in_s, new_in_e;
  logic                  old_shift, new_shift, copy_back;

  state_t              state_r, state_nxt;
  logic [IdxBits-1:0]  step_r, step_nxt;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;    // committed entries
  logic [CntBits-1:0]  ncnt_r, ncnt_nxt;  // entries produced in scan
  logic [1:0]          mode_r;
  logic [COORD_BITS-1:0] s_r, s_nxt, e_r, e_nxt;
  logic                placed_r, placed_nxt, hit_r, hit_nxt, ovf_r, ovf_nxt;
  logic                empty_r;
  logic [IdxBits-1:0]  rot_r, rot_nxt;    // align turn, then copy-back sweep
  out_word_t           res_r, res_nxt;
  logic                vld_r, vld_nxt;

  // Emission of up to two words per visit goes through a small queue.
  logic                emit0, emit1;
  logic [COORD_BITS-1:0] e0s, e0e, e1s, e1e;
  logic                pend_r, pend_nxt;
  logic [COORD_BITS-1:0] ps_r, pe_r, ps_nxt, pe_nxt;

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cells
    if (g == MAX_RANGES - 1) begin : g_last
      ist_cell #(.CoordBits(COORD_BITS)) u_old (
        .clk, .shift(old_shift), .nb_start(old_in_s), .nb_end(old_in_e),
        .cur_start(old_s[g]), .cur_end(old_e[g]));
      ist_cell #(.CoordBits(COORD_BITS)) u_new (
        .clk, .shift(new_shift), .nb_start(new_in_s), .nb_end(new_in_e),
        .cur_start(new_s[g]), .cur_end(new_e[g]));
    end else begin : g_mid
      ist_cell #(.CoordBits(COORD_BITS)) u_old (
        .clk, .shift(old_shift), .nb_start(old_s[g+1]), .nb_end(old_e[g+1]),
        .cur_start(old_s[g]), .cur_end(old_e[g]));
      ist_cell #(.CoordBits(COORD_BITS)) u_new (
        .clk, .shift(new_shift), .nb_start(new_s[g+1]), .nb_end(new_e[g+1]),
        .cur_start(new_s[g]), .cur_end(new_e[g]));
    end
  end

  logic [COORD_BITS-1:0] a, b, in_s, in_e;
  logic                  cur_ok;
  assign in_s   = COORD_BITS'(in_word.range_start[InBits-1:0]);
  assign in_e   = COORD_BITS'(in_word.range_end[InBits-1:0]);
  assign a      = old_s[0];
  assign b      = old_e[0];
  assign cur_ok = ({1'b0, step_r} < (IdxBits+1)'(cnt_r));

  // New ring takes one word per cycle; a pending word goes out first.
  always_comb begin
    new_shift = 1'b0;
    new_in_s  = ps_r;
    new_in_e  = pe_r;
    pend_nxt  = pend_r;
    ps_nxt    = ps_r;
    pe_nxt    = pe_r;
    if (pend_r) begin
      new_shift = 1'b1;
      pend_nxt  = emit0 | emit1;
      if (emit0) begin
        ps_nxt = e0s; pe_nxt = e0e;
      end else if (emit1) begin
        ps_nxt = e1s; pe_nxt = e1e;
      end
      if (emit0 && emit1) begin
        ps_nxt = e0s; pe_nxt = e0e; // cannot happen after a pending word
      end
    end else if (emit0) begin
      new_shift = 1'b1;
      new_in_s  = e0s;
      new_in_e  = e0e;
      if (emit1) begin
        pend_nxt = 1'b1; ps_nxt = e1s; pe_nxt = e1e;
      end
    end else if (emit1) begin
      new_shift = 1'b1;
      new_in_s  = e1s;
      new_in_e  = e1e;
    end
    // rotate the new ring on itself
    if (copy_back) begin
      new_shift = 1'b1;
      new_in_s  = new_s[0];
      new_in_e  = new_e[0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    ncnt_nxt  = ncnt_r;
    s_nxt     = s_r;
    e_nxt     = e_r;
    placed_nxt = placed_r;
    hit_nxt   = hit_r;
    ovf_nxt   = ovf_r;
    rot_nxt   = rot_r;
    res_nxt   = res_r;
    vld_nxt   = 1'b0;
    old_shift = 1'b0;
    old_in_s  = a;
    old_in_e  = b;
    copy_back = 1'b0;
    emit0 = 1'b0; emit1 = 1'b0;
    e0s = a; e0e = b; e1s = a; e1e = b;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
          step_nxt  = '0;
          ncnt_nxt  = '0;
          s_nxt     = in_s;
          e_nxt     = in_e;
          placed_nxt = 1'b0;
          hit_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        old_shift = 1'b1; // rotate the old ring, one full turn
        if (cur_ok && !empty_r) begin
          case (mode_t'(mode_r))
            MODE_ADD: begin
              if (b < s_r) begin
                emit0 = 1'b1;
              end else if (a > e_r) begin
                emit0 = !placed_r; e0s = s_r; e0e = e_r;
                emit1 = 1'b1;
                placed_nxt = 1'b1;
              end else begin
                if (a < s_r) s_nxt = a;
                if (b > e_r) e_nxt = b;
              end
            end
            MODE_REMOVE: begin
              if (b <= s_r || a >= e_r) begin
                emit0 = 1'b1;
              end else begin
                emit0 = (a < s_r); e0s = a;   e0e = s_r;
                emit1 = (b > e_r); e1s = e_r; e1e = b;
              end
            end
            MODE_QUERY: begin
              if (a <= s_r && e_r <= b) hit_nxt = 1'b1;
            end
            default: ;
          endcase
        end
        if ((mode_t'(mode_r) == MODE_ADD) && !empty_r && !placed_r
            && step_r == IdxBits'(MAX_RANGES)) begin
          emit0 = 1'b1; e0s = s_r; e0e = e_r; placed_nxt = 1'b1;
        end
        if (step_r == IdxBits'(MAX_RANGES)) old_shift = 1'b0;
        ncnt_nxt = ncnt_r + CntBits'(emit0) + CntBits'(emit1);
        if (ncnt_nxt > CntBits'(MAX_RANGES)) ovf_nxt = 1'b1;
        if (step_r == IdxBits'(MAX_RANGES)) begin
          if (!pend_r) begin
            if (!ovf_nxt && !empty_r &&
                (mode_t'(mode_r) == MODE_ADD || mode_t'(mode_r) == MODE_REMOVE)) begin
              state_nxt = ST_ALIGN;
              rot_nxt   = IdxBits'(ncnt_nxt);
            end else begin
              state_nxt = ST_DONE;
              rot_nxt   = '0;
            end
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_ALIGN: begin
        // Turn the new ring until its first entry sits in slot 0.
        if (rot_r == IdxBits'(MAX_RANGES)) begin
          state_nxt = ST_DONE;
          rot_nxt   = '0;
        end else begin
          copy_back = 1'b1;
          rot_nxt   = rot_r + 1'b1;
        end
      end
      ST_DONE: begin
        // Commit after a non-empty add or remove that fits: rotate the new ring into the old ring, one cell a cycle.
        if (!ovf_r && !empty_r &&
            (mode_t'(mode_r) == MODE_ADD || mode_t'(mode_r) == MODE_REMOVE)) begin
          old_shift = 1'b1;
          copy_back = 1'b1;
          old_in_s  = new_s[0];
          old_in_e  = new_e[0];
        end
        if (rot_r == IdxBits'(MAX_RANGES - 1)) begin
          state_nxt = ST_IDLE;
          vld_nxt   = 1'b1;
          res_nxt.covered    = (mode_t'(mode_r) == MODE_QUERY) && !empty_r && hit_r;
          res_nxt.table_full = ovf_r && !empty_r &&
            (mode_t'(mode_r) == MODE_ADD || mode_t'(mode_r) == MODE_REMOVE);
          if (!ovf_r && !empty_r &&
              (mode_t'(mode_r) == MODE_ADD || mode_t'(mode_r) == MODE_REMOVE))
            cnt_nxt = ncnt_r;
        end else begin
          rot_nxt = rot_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      pend_r  <= (state_r == ST_SCAN) ? pend_nxt : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    ncnt_r   <= ncnt_nxt;
    s_r      <= s_nxt;
    e_r      <= e_nxt;
    placed_r <= placed_nxt;
    hit_r    <= hit_nxt;
    ovf_r    <= ovf_nxt;
    rot_r    <= rot_nxt;
    res_r    <= res_nxt;
    ps_r     <= ps_nxt;
    pe_r     <= pe_nxt;
    if (state_r == ST_IDLE && start) begin
      mode_r  <= in_word.mode;
      empty_r <= !(in_s < in_e);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = vld_r;
  assign out_word  = res_r;
endmodule : interval_set_table_top
`default_nettype wire

// ----- rtl/core/ist_cell.sv -----
`default_nettype none
// One table slot. During a scan the contents rotate one place toward slot 0
// each cycle; the slot-0 output feeds the sequencer, which writes back into
// the last slot. Content of a slot is only meaningful below the fill count.
module ist_cell #(
  parameter int unsigned CoordBits = ist_pkg::CoordBitsDef
) (
  input  wire logic                 clk,
  input  wire logic                 shift,
  input  wire logic [CoordBits-1:0] nb_start,
  input  wire logic [CoordBits-1:0] nb_end,
  output logic      [CoordBits-1:0] cur_start,
  output logic      [CoordBits-1:0] cur_end
);
  logic [CoordBits-1:0] start_r, end_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      start_r <= nb_start;
      end_r   <= nb_end;
    end
  end

  assign cur_start = start_r;
  assign cur_end   = end_r;
endmodule : ist_cell
`default_nettype wire

// ----- rtl/core/ist_checker.sv -----
`default_nettype none
module ist_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire ist_pkg::in_word_t in_word,
  input wire logic              out_valid,
  input wire ist_pkg::out_word_t out_word
);
  import ist_pkg::*;

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.covered && out_word.table_full))
    else $error("covered and table_full together");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without result");
endmodule : ist_checker

bind interval_set_table_top ist_checker u_ist_checker (
  .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word);
`default_nettype wire

// ----- tb/sv/interval_set_table_top_test.sv -----
module interval_set_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ist_pkg::*;

  localparam int unsigned TableDepth = 16;
  // allow plenty of slack after the last expected result
  localparam int unsigned DrainCycles = 4 * (3 * TableDepth + 3);

  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
  } span_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  interval_set_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // local copy of the interval table, kept sorted by lower bound
  span_t     spans[$];
  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  int unsigned mismatches = 0;
  int unsigned unexpected = 0;
  int unsigned results_seen = 0;
  int unsigned full_seen = 0;
  int unsigned covered_seen = 0;
  int unsigned words_sent = 0;

  // Add: merge every interval that overlaps or touches [s,e).
  function automatic bit table_add(logic [31:0] s, logic [31:0] e);
    span_t fresh[$];
    span_t item;
    bit    placed;
    placed = 1'b0;
    foreach (spans[i]) begin
      if (spans[i].hi < s) begin
        fresh = {fresh, spans[i]};
      end else if (spans[i].lo > e) begin
        if (!placed) begin
          item.lo = s;
          item.hi = e;
          fresh = {fresh, item};
          placed = 1'b1;
        end
        fresh = {fresh, spans[i]};
      end else begin
        if (spans[i].lo < s) s = spans[i].lo;
        if (spans[i].hi > e) e = spans[i].hi;
      end
    end
    if (!placed) begin
      item.lo = s;
      item.hi = e;
      fresh = {fresh, item};
    end
    if (fresh.size() > TableDepth) return 1'b1;
    spans = fresh;
    return 1'b0;
  endfunction

  // Remove: trim, split or drop covered intervals.
  function automatic bit table_remove(logic [31:0] s, logic [31:0] e);
    span_t fresh[$];
    span_t item;
    foreach (spans[i]) begin
      if (spans[i].hi <= s || spans[i].lo >= e) begin
        fresh = {fresh, spans[i]};
      end else begin
        if (spans[i].lo < s) begin
          item.lo = spans[i].lo;
          item.hi = s;
          fresh = {fresh, item};
        end
        if (spans[i].hi > e) begin
          item.lo = e;
          item.hi = spans[i].hi;
          fresh = {fresh, item};
        end
      end
    end
    if (fresh.size() > TableDepth) return 1'b1;
    spans = fresh;
    return 1'b0;
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.range_start < w.range_end) begin
      case (mode_t'(w.mode))
        MODE_ADD:    r.table_full = table_add(w.range_start, w.range_end);
        MODE_REMOVE: r.table_full = table_remove(w.range_start, w.range_end);
        MODE_QUERY: begin
          foreach (spans[i])
            if (spans[i].lo <= w.range_start && w.range_end <= spans[i].hi)
              r.covered = 1'b1;
        end
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic void queue_word(mode_t m, logic [31:0] s, logic [31:0] e);
    in_word_t w;
    w.mode = m;
    w.range_start = s;
    w.range_end = e;
    pending_words = {pending_words, w};
  endfunction

  // Coordinates mostly in a small window so intervals collide, merge and split;
  // now and then anywhere in the 32-bit space.
  function automatic logic [31:0] pick_coord(logic [31:0] base);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 300);
      default: return base + $urandom_range(0, 300);
    endcase
  endfunction

  // Driver: start is raised at random; an accepted word is predicted at the
  // edge that takes it. Words 600 to 799 go out with no idling.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results = {expected_results, predict_result(in_word)};
        words_sent <= words_sent + 1;
      end
      if (!(start && busy)) begin
        if (pending_words.size() != 0 &&
            ((words_sent >= 600 && words_sent < 800) ||
             $urandom_range(0, 99) >= 26)) begin
          in_word <= pending_words.pop_front();
          start   <= 1'b1;
        end else begin
          start   <= 1'b0;
          in_word <= {2'($urandom()), $urandom(), $urandom()};
        end
      end
    end
  end

  // Monitor: every strobe is checked against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: covered %b table_full %b",
                   out_word.covered, out_word.table_full);
      end else begin
        want = expected_results.pop_front();
        if (want.covered) covered_seen++;
        if (want.table_full) full_seen++;
        if (out_word.covered !== want.covered ||
            out_word.table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: covered exp %b got %b, table_full exp %b got %b",
                     $realtime, want.covered, out_word.covered,
                     want.table_full, out_word.table_full);
        end
      end
    end
  end

  initial begin
    logic [31:0] base;
    logic [31:0] s;
    logic [31:0] e;
    int unsigned k;
    mode_t       m;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table query, extremes, empty range, unused mode,
    // merge on touch, split, and fill to overflow
    queue_word(MODE_QUERY, 32'd0, 32'd1);
    queue_word(MODE_ADD, 32'd0, 32'hFFFF_FFFF);
    queue_word(MODE_QUERY, 32'd0, 32'hFFFF_FFFF);
    queue_word(MODE_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_word(MODE_REMOVE, 32'd0, 32'hFFFF_FFFF);
    queue_word(MODE_ADD, 32'd50, 32'd50);
    queue_word(MODE_ADD, 32'd60, 32'd40);
    queue_word(MODE_QUERY, 32'd40, 32'd40);
    queue_word(MODE_NONE, 32'd0, 32'd100);
    queue_word(MODE_ADD, 32'd10, 32'd20);
    queue_word(MODE_ADD, 32'd20, 32'd30);
    queue_word(MODE_QUERY, 32'd10, 32'd30);
    queue_word(MODE_REMOVE, 32'd14, 32'd16);
    queue_word(MODE_QUERY, 32'd10, 32'd30);
    for (int i = 0; i < 16; i++) queue_word(MODE_ADD, 100 + 4 * i, 102 + 4 * i);
    queue_word(MODE_ADD, 32'd500, 32'd501);
    queue_word(MODE_REMOVE, 32'd11, 32'd12);
    queue_word(MODE_REMOVE, 32'd0, 32'd1000);
    queue_word(MODE_REMOVE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);

    // random: mostly valid ranges in a busy window, some noise
    for (int i = 0; i < 1300; i++) begin
      if (i % 200 == 0) base = $urandom() & 32'hFFFF_F000;
      k = $urandom_range(0, 99);
      m = (k < 40) ? MODE_ADD : (k < 70) ? MODE_REMOVE : (k < 97) ? MODE_QUERY
                                                                 : MODE_NONE;
      s = pick_coord(base);
      e = ($urandom_range(0, 9) == 0) ? pick_coord(base) : s + $urandom_range(1, 40);
      if (e < s && $urandom_range(0, 3) != 0) e = 32'hFFFF_FFFF;
      queue_word(m, s, e);
    end

    wait (pending_words.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d words taken, %0d results checked (%0d covered, %0d table full)",
             words_sent, results_seen, covered_seen, full_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatches, unexpected);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ~1350 words plus idling finish far below this timeout
  initial begin
    #5ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule
